/* sv/alifd_pkg.sv */
package alifd_pkg;

	localparam int CAPACITY = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_FIND   = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_BAD_POS   = 3'd2,
		ST_EMPTY_POS = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

/* sv/alifd_ctrl.sv */
module alifd_ctrl
	import alifd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			CS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

/* sv/alifd_dp.sv */
module alifd_dp
	import alifd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  action,
	input  logic [31:0] item_value,
	input  logic [8:0]  slot_index,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic [7:0]  found_index
);

	logic [31:0]      entries_q [CAPACITY];
	logic [31:0]      entries_d [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic [1:0]  act_q;
	logic [31:0] value_q;
	logic [8:0]  slot_q;

	logic        out_valid_q;
	status_t     out_status_q;
	logic [7:0]  out_index_q;

	status_t     res_status;
	logic [7:0]  res_index;
	logic        pos_neg;
	logic [8:0]  pos_u;
	logic [8:0]  cnt9;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			value_q <= item_value;
			slot_q  <= slot_index;
		end
	end

	always_comb begin
		entries_d  = entries_q;
		count_d    = count_q;
		res_status = ST_OK;
		res_index  = '0;
		pos_neg    = slot_q[8];
		pos_u      = {1'b0, slot_q[7:0]};
		cnt9       = 9'(count_q);
		case (act_q)
			ACT_INSERT: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					res_status = ST_FULL;
				end else if (pos_neg || pos_u > cnt9) begin
					res_status = ST_BAD_POS;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (9'(i) == pos_u) begin
							entries_d[i] = value_q;
						end else if (9'(i) > pos_u) begin
							entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
						end
					end
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_FIND: begin
				res_status = ST_NOT_FOUND;
				for (int i = CAPACITY - 1; i >= 0; i--) begin
					if (9'(i) < cnt9 && entries_q[i] == value_q) begin
						res_status = ST_OK;
						res_index  = 8'(i);
					end
				end
			end
			ACT_DELETE: begin
				if (pos_neg || pos_u >= cnt9) begin
					res_status = ST_EMPTY_POS;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (9'(i) >= pos_u) begin
							entries_d[i] = entries_q[(i + 1 < CAPACITY) ? i + 1 : i];
						end
					end
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			entries_q    <= entries_d;
			out_status_q <= res_status;
			out_index_q  <= res_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found_index  = out_index_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && act_q == ACT_INSERT && res_status == ST_OK
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && res_status != ST_OK |=> count_q == $past(count_q))
		else $error("failed request changed the count");

	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> sts.out_free)
		else $error("result overwritten before it was taken");

	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_index_q != 8'd0 |-> out_status_q == ST_OK)
		else $error("position given with a failing status");
`endif

endmodule

/* sv/array_list_insert_find_delete.sv */
// a request is registered in the controller's load step on acceptance, and its
// result in the execute step once the result register is free; no new request
// enters until then; all entries shift or compare in parallel in the execute step
// the result register lets the next request in while a result waits
// reset clears the entry count, the controller and the result valid flag;
// entry storage is not cleared
module array_list_insert_find_delete
	import alifd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // item_value[31:0], slot_index[40:32], zero pad
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // found_index[7:0]
	output logic [2:0]  m_tuser   // status[2:0]
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	alifd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	alifd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (s_tuser),
		.item_value  (s_tdata[31:0]),
		.slot_index  (s_tdata[40:32]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.status      (m_tuser),
		.found_index (m_tdata)
	);

endmodule

/* bench/tb_top.sv */
module tb_top;
	import alifd_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int PHASE_ITEMS = 342;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		status_t    status;
		logic [7:0] found_index;
	} list_reply_t;

	class list_shadow;
		logic [31:0]  slots [CAPACITY];
		int           fill;
		list_reply_t  pending_replies [$];
		int           errors;
		int           replies;
		int           action_hits [4];
		int           status_hits [5];

		function new();
			fill = 0;
			errors = 0;
			replies = 0;
			foreach (action_hits[i]) action_hits[i] = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function void apply_request(logic [1:0] act, logic [31:0] val, logic signed [8:0] slot);
			list_reply_t r;
			int p;
			int i;
			p = int'(slot);
			r.status = ST_OK;
			r.found_index = 8'd0;
			action_hits[act]++;
			case (act)
				ACT_INSERT: begin
					if (fill >= CAPACITY) begin
						r.status = ST_FULL;
					end else if (p < 0 || p > fill) begin
						r.status = ST_BAD_POS;
					end else begin
						for (i = fill; i > p; i--) slots[i] = slots[i - 1];
						slots[p] = val;
						fill++;
					end
				end
				ACT_FIND: begin
					r.status = ST_NOT_FOUND;
					for (i = 0; i < fill; i++) begin
						if (slots[i] == val) begin
							r.status = ST_OK;
							r.found_index = i[7:0];
							break;
						end
					end
				end
				ACT_DELETE: begin
					if (p < 0 || p >= fill) begin
						r.status = ST_EMPTY_POS;
					end else begin
						for (i = p; i + 1 < fill; i++) slots[i] = slots[i + 1];
						fill--;
					end
				end
				default: ;
			endcase
			status_hits[r.status]++;
			pending_replies.push_back(r);
		endfunction

		function void match_reply(logic [2:0] st, logic [7:0] idx);
			list_reply_t want;
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, status %0d found_index %0d",
					$time, st, idx);
				return;
			end
			want = pending_replies.pop_front();
			replies++;
			if (st !== want.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, want.status, st);
			end
			if (idx !== want.found_index) begin
				errors++;
				$display("%0t: found_index mismatch, expected %0d actual %0d",
					$time, want.found_index, idx);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;

	list_shadow  shadow;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          cycles;
	logic [31:0] value_pool [6];

	array_list_insert_find_delete DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_request(logic [1:0] act, logic [31:0] val, logic signed [8:0] slot);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, slot, val};
		do @(posedge clk); while (!s_tready);
		shadow.apply_request(act, val, slot);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(99) < 70) return value_pool[$urandom_range(5)];
		return $urandom;
	endfunction

	task automatic send_random();
		logic [1:0]        act;
		logic [31:0]       val;
		logic signed [8:0] slot;
		int                r;
		r = $urandom_range(99);
		if (r < 40) act = ACT_INSERT;
		else if (r < 70) act = ACT_FIND;
		else if (r < 95) act = ACT_DELETE;
		else act = ACT_NONE;
		val = pick_value();
		slot = 9'($urandom);
		case (act)
			ACT_INSERT: begin
				if ($urandom_range(99) < 75) slot = 9'($urandom_range(shadow.fill));
			end
			ACT_FIND: begin
				if (shadow.fill > 0 && $urandom_range(99) < 70)
					val = shadow.slots[$urandom_range(shadow.fill - 1)];
			end
			ACT_DELETE: begin
				if (shadow.fill > 0 && $urandom_range(99) < 75)
					slot = 9'($urandom_range(shadow.fill - 1));
			end
			default: ;
		endcase
		send_request(act, val, slot);
	endtask

	// result side
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) shadow.match_reply(m_tuser, m_tdata);
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		int i;
		shadow = new();
		value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0011, 32'hDEAD_BEEF};
		tx_idle_pct = 29;
		rx_idle_pct = 66;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_request(ACT_FIND,   32'd5, 9'sd0);
		send_request(ACT_DELETE, 32'd0, 9'sd0);
		send_request(ACT_INSERT, 32'd1, -9'sd1);
		send_request(ACT_INSERT, 32'd1, 9'sd1);
		// fill up, extremes of value
		send_request(ACT_INSERT, 32'h8000_0000, 9'sd0);
		send_request(ACT_INSERT, 32'h7FFF_FFFF, 9'sd1);
		send_request(ACT_INSERT, 32'h0000_0000, 9'sd0);
		send_request(ACT_INSERT, 32'hFFFF_FFFF, 9'sd1);
		send_request(ACT_INSERT, 32'h5555_5555, 9'sd4);
		send_request(ACT_INSERT, 32'hAAAA_AAAA, 9'sd2);
		send_request(ACT_INSERT, 32'hFFFF_FFFF, 9'sd6);
		send_request(ACT_INSERT, 32'd9, 9'sd255);
		send_request(ACT_INSERT, 32'd7, 9'sd0);
		// full list, full wins over a bad position
		send_request(ACT_INSERT, 32'd3, -9'sd256);
		send_request(ACT_INSERT, 32'd3, 9'sd3);
		send_request(ACT_FIND,   32'hFFFF_FFFF, 9'sd0);
		send_request(ACT_FIND,   32'h7FFF_FFFF, 9'sd0);
		send_request(ACT_FIND,   32'd7, 9'sd0);
		send_request(ACT_FIND,   32'd12345, 9'sd0);
		send_request(ACT_NONE,   32'hFFFF_FFFF, -9'sd1);
		send_request(ACT_DELETE, 32'd0, 9'sd8);
		send_request(ACT_DELETE, 32'd0, -9'sd256);
		send_request(ACT_DELETE, 32'd0, 9'sd255);
		send_request(ACT_DELETE, 32'd0, 9'sd7);
		send_request(ACT_DELETE, 32'd0, 9'sd0);
		send_request(ACT_DELETE, 32'd0, 9'sd3);

		for (i = 0; i < PHASE_ITEMS; i++) send_random();
		tx_idle_pct = 66;
		rx_idle_pct = 29;
		for (i = 0; i < PHASE_ITEMS; i++) send_random();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (i = 0; i < PHASE_ITEMS; i++) send_random();
		s_tvalid <= 1'b0;

		while (shadow.pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests: %0d insert, %0d find, %0d delete, %0d unused action",
			shadow.action_hits[0] + shadow.action_hits[1] + shadow.action_hits[2]
			+ shadow.action_hits[3], shadow.action_hits[0], shadow.action_hits[1],
			shadow.action_hits[2], shadow.action_hits[3]);
		$display("%0d results: ok %0d, full %0d, bad position %0d, empty position %0d, not found %0d",
			shadow.replies, shadow.status_hits[0], shadow.status_hits[1],
			shadow.status_hits[2], shadow.status_hits[3], shadow.status_hits[4]);
		if (shadow.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/alifd_pkg.sv
sv/alifd_ctrl.sv
sv/alifd_dp.sv
sv/array_list_insert_find_delete.sv
bench/tb_top.sv
